[rtl/sfr_pkg.sv]
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int MAX_FRAME_BYTES = 1024;
   localparam int HEAD_BYTES      = 4;

   localparam int BYTE_W  = 8;
   localparam int ROLE_W  = 3;
   localparam int INDEX_W = 10;
   localparam int STATUS_W = 2;
   localparam int FLEN_W  = 11;
   localparam int COUNT_W = 11;
   localparam int SUM_W   = 32;
   localparam int PHASE_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME_BYTES - HEAD_BYTES);

   localparam logic [0:0] CMD_BYTE = 1'd0;
   localparam logic [0:0] CMD_IDLE = 1'd1;

   localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_TAG     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LENHI   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LENLO   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CSUM    = 3'd5;

   localparam logic [ROLE_W-1:0] ROLE_NONE    = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_HEADER  = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_TAG     = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
   localparam logic [ROLE_W-1:0] ROLE_CSUM    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CSUM_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_VALUE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT   = 2'd2;

   localparam logic [7:0]  HEADER_RESET      = 8'hE7;
   localparam logic [9:0]  MAX_PAYLOAD_RESET = 10'd1020;
   localparam logic [31:0] IDLE_LIMIT_RESET  = 32'd5000000;

   typedef struct packed {
      logic [0:0]        cmd;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [ROLE_W-1:0]   byte_role;
      logic [INDEX_W-1:0]  payload_index;
      logic                frame_done;
      logic [STATUS_W-1:0] frame_status;
      logic [FLEN_W-1:0]   frame_length;
   } result_type;

   typedef struct packed {
      logic [7:0]  header_value;
      logic [9:0]  max_payload;
      logic [31:0] idle_limit;
   } cfg_type;

endpackage

[rtl/sfr_if.sv]
`timescale 1ns / 1ps

interface sfr_req_if;
   logic                      valid;
   logic                      ready;
   logic [0:0]                cmd;
   logic [sfr_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfr_pkg::BYTE_W-1:0]    out_byte;
   logic [sfr_pkg::ROLE_W-1:0]    byte_role;
   logic [sfr_pkg::INDEX_W-1:0]   payload_index;
   logic                          frame_done;
   logic [sfr_pkg::STATUS_W-1:0]  frame_status;
   logic [sfr_pkg::FLEN_W-1:0]    frame_length;
   modport source (output valid, output out_byte, output byte_role, output payload_index,
                   output frame_done, output frame_status, output frame_length,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_role, input payload_index,
                   input frame_done, input frame_status, input frame_length,
                   output ready);
endinterface

interface sfr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sfr_pkg::CSR_INDEX_W-1:0]   index;
   logic [sfr_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sfr_csr.sv]
`timescale 1ns / 1ps

module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   wr_data,
   output sfr_pkg::cfg_type                 cfg
);

   sfr_pkg::cfg_type cfg_ff;
   sfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            sfr_pkg::CSR_HEADER_VALUE: cfg_in.header_value = wr_data[7:0];
            sfr_pkg::CSR_MAX_PAYLOAD:  cfg_in.max_payload  = wr_data[9:0];
            sfr_pkg::CSR_IDLE_LIMIT:   cfg_in.idle_limit   = wr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= sfr_pkg::HEADER_RESET;
         cfg_ff.max_payload  <= sfr_pkg::MAX_PAYLOAD_RESET;
         cfg_ff.idle_limit   <= sfr_pkg::IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/sfr_deframer.sv]
`timescale 1ns / 1ps

module sfr_deframer (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  sfr_pkg::item_type   item,
   input  sfr_pkg::cfg_type    cfg,
   output sfr_pkg::result_type result
);

   logic [sfr_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]                  length_high_ff, length_high_in;
   logic [9:0]                  payload_length_ff, payload_length_in;
   logic [sfr_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [sfr_pkg::SUM_W-1:0]   running_sum_ff, running_sum_in;
   logic                        sum_match_ff, sum_match_in;
   logic [31:0]                 idle_count_ff, idle_count_in;

   logic [15:0]                 len;
   logic [31:0]                 idle_next;
   logic [sfr_pkg::COUNT_W-1:0] count_inc;
   logic [7:0]                  expect_byte;
   logic                        match_now;
   logic [sfr_pkg::SUM_W-1:0]   sum_add;
   logic [7:0]                  b;

   assign b         = item.rx_byte;
   assign len       = {length_high_ff, b};
   assign idle_next = (idle_count_ff == '1) ? idle_count_ff : idle_count_ff + 32'd1;
   assign count_inc = byte_count_ff + sfr_pkg::COUNT_W'(1);
   assign sum_add   = running_sum_ff + sfr_pkg::SUM_W'(b);

   always_comb begin
      unique case (byte_count_ff[1:0])
         2'd0: expect_byte = running_sum_ff[31:24];
         2'd1: expect_byte = running_sum_ff[23:16];
         2'd2: expect_byte = running_sum_ff[15:8];
         default: expect_byte = running_sum_ff[7:0];
      endcase
   end

   assign match_now = sum_match_ff && (expect_byte == b);

   always_comb begin
      phase_in          = phase_ff;
      length_high_in    = length_high_ff;
      payload_length_in = payload_length_ff;
      byte_count_in     = byte_count_ff;
      running_sum_in    = running_sum_ff;
      sum_match_in      = sum_match_ff;
      idle_count_in     = idle_count_ff;
      result            = '0;

      if (item.cmd == sfr_pkg::CMD_IDLE) begin
         if (phase_ff != sfr_pkg::PH_HUNT) begin
            if (idle_next > cfg.idle_limit) begin
               phase_in            = sfr_pkg::PH_HUNT;
               idle_count_in       = '0;
               result.frame_done   = 1'b1;
               result.frame_status = sfr_pkg::ST_TIMEOUT;
            end else begin
               idle_count_in = idle_next;
            end
         end
      end else begin
         idle_count_in   = '0;
         result.out_byte = b;
         unique case (phase_ff)
            sfr_pkg::PH_TAG: begin
               running_sum_in   = sum_add;
               phase_in         = sfr_pkg::PH_LENHI;
               result.byte_role = sfr_pkg::ROLE_TAG;
            end
            sfr_pkg::PH_LENHI: begin
               running_sum_in   = sum_add;
               length_high_in   = b;
               phase_in         = sfr_pkg::PH_LENLO;
               result.byte_role = sfr_pkg::ROLE_LENGTH;
            end
            sfr_pkg::PH_LENLO: begin
               running_sum_in   = sum_add;
               result.byte_role = sfr_pkg::ROLE_LENGTH;
               priority if (len == 16'd0) begin
                  phase_in = sfr_pkg::PH_HUNT;
               end else if (len > 16'(cfg.max_payload) || len > sfr_pkg::LEN_LIMIT) begin
                  phase_in            = sfr_pkg::PH_HUNT;
                  result.frame_done   = 1'b1;
                  result.frame_status = sfr_pkg::ST_TOO_LONG;
               end else begin
                  payload_length_in = len[9:0];
                  byte_count_in     = '0;
                  phase_in          = sfr_pkg::PH_PAYLOAD;
               end
            end
            sfr_pkg::PH_PAYLOAD: begin
               running_sum_in       = sum_add;
               result.byte_role     = sfr_pkg::ROLE_PAYLOAD;
               result.payload_index = byte_count_ff[sfr_pkg::INDEX_W-1:0];
               if (count_inc >= sfr_pkg::COUNT_W'(payload_length_ff)) begin
                  byte_count_in = '0;
                  phase_in      = sfr_pkg::PH_CSUM;
               end else begin
                  byte_count_in = count_inc;
               end
            end
            sfr_pkg::PH_CSUM: begin
               sum_match_in     = match_now;
               result.byte_role = sfr_pkg::ROLE_CSUM;
               if (count_inc >= sfr_pkg::COUNT_W'(4)) begin
                  phase_in          = sfr_pkg::PH_HUNT;
                  byte_count_in     = '0;
                  result.frame_done = 1'b1;
                  if (match_now) begin
                     result.frame_status = sfr_pkg::ST_GOOD;
                     result.frame_length = sfr_pkg::FLEN_W'(payload_length_ff)
                                           + sfr_pkg::FLEN_W'(8);
                  end else begin
                     result.frame_status = sfr_pkg::ST_CSUM_BAD;
                  end
               end else begin
                  byte_count_in = count_inc;
               end
            end
            default: begin
               phase_in = sfr_pkg::PH_HUNT;
               if (b == cfg.header_value) begin
                  running_sum_in   = sfr_pkg::SUM_W'(b);
                  sum_match_in     = 1'b1;
                  byte_count_in    = '0;
                  phase_in         = sfr_pkg::PH_TAG;
                  result.byte_role = sfr_pkg::ROLE_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= sfr_pkg::PH_HUNT;
         length_high_ff    <= '0;
         payload_length_ff <= '0;
         byte_count_ff     <= '0;
         running_sum_ff    <= '0;
         sum_match_ff      <= 1'b1;
         idle_count_ff     <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         length_high_ff    <= length_high_in;
         payload_length_ff <= payload_length_in;
         byte_count_ff     <= byte_count_in;
         running_sum_ff    <= running_sum_in;
         sum_match_ff      <= sum_match_in;
         idle_count_ff     <= idle_count_in;
      end
   end

   a_hunt_no_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfr_pkg::PH_HUNT |-> idle_count_ff == '0)
      else $error("idle count left over while hunting");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      result.byte_role == sfr_pkg::ROLE_PAYLOAD
      |-> 10'(result.payload_index) < payload_length_ff)
      else $error("payload index beyond payload length");

   a_done_to_hunt: assert property (@(posedge clock) disable iff (reset)
      step && result.frame_done |=> phase_ff == sfr_pkg::PH_HUNT)
      else $error("frame ended but hunt not resumed");

   a_good_is_csum: assert property (@(posedge clock) disable iff (reset)
      result.frame_done && result.frame_status == sfr_pkg::ST_GOOD
      |-> result.byte_role == sfr_pkg::ROLE_CSUM && phase_ff == sfr_pkg::PH_CSUM)
      else $error("good frame end outside checksum");

endmodule

[rtl/sum_checked_frame_receiver.sv]
`timescale 1ns / 1ps

// channel  | role        | beat
// req_bus  | sink        | cmd, rx_byte (byte or idle tick)
// rsp_bus  | source      | out_byte, byte_role, payload_index, frame_done, frame_status, frame_length
// csr_bus  | sink        | index, data (register write)
//
// One beat per cycle sustained while rsp_bus is not stalled; a taken beat passes
// through the input register, deframer logic and result register to rsp_bus.
// Reset is synchronous; it clears frame state and restores register defaults.
// A stall on rsp_bus holds the result; one more beat waits in the input register.
// Register writes are taken every cycle.

module sum_checked_frame_receiver (
   input logic       clock,
   input logic       reset,
   sfr_req_if.sink   req_bus,
   sfr_rsp_if.source rsp_bus,
   sfr_csr_if.sink   csr_bus
);

   logic                in_valid_ff;
   sfr_pkg::item_type   in_item_ff;
   logic                out_valid_ff;
   sfr_pkg::result_type out_res_ff;

   logic                out_load;
   logic                step;
   sfr_pkg::cfg_type    cfg;
   sfr_pkg::result_type res;

   assign out_load       = !out_valid_ff || rsp_bus.ready;
   assign step           = in_valid_ff && out_load;
   assign req_bus.ready  = !in_valid_ff || out_load;
   assign csr_bus.ready  = 1'b1;

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   sfr_deframer u_deframer (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.cmd     <= req_bus.cmd;
         in_item_ff.rx_byte <= req_bus.rx_byte;
      end
      if (step) begin
         out_res_ff <= res;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.out_byte      = out_res_ff.out_byte;
   assign rsp_bus.byte_role     = out_res_ff.byte_role;
   assign rsp_bus.payload_index = out_res_ff.payload_index;
   assign rsp_bus.frame_done    = out_res_ff.frame_done;
   assign rsp_bus.frame_status  = out_res_ff.frame_status;
   assign rsp_bus.frame_length  = out_res_ff.frame_length;

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_res_ff))
      else $error("result changed while stalled");

   a_in_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_item_ff))
      else $error("input beat lost while stalled");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed beat did not reach result register");

endmodule
